// File: src/wft_pkg.sv
// ----------------------------------------------------------------------------
// Word frequency table package
// Shared widths, byte constants and helpers for the sorted word table.
// ----------------------------------------------------------------------------
package wft_pkg;

  localparam int WORD_BYTES = 16;
  localparam int WORD_BITS  = 8 * WORD_BYTES;
  localparam int LEN_W      = 5;
  localparam int RANK_W     = 10;
  localparam int TOTAL_W    = 11;
  localparam int OUT_COUNT_W = 24;
  localparam int HALF_BITS  = 64;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [7:0]        text_byte;
    logic [RANK_W-1:0] rank;
  } in_item_t;

  typedef struct packed {
    logic [HALF_BITS-1:0]   word_first_chars;
    logic [HALF_BITS-1:0]   word_last_chars;
    logic [LEN_W-1:0]       word_length;
    logic [OUT_COUNT_W-1:0] word_count;
    logic                   entry_valid;
    logic [TOTAL_W-1:0]     distinct_words;
    logic                   table_overflow;
    logic                   word_truncated;
  } out_item_t;

  // Word strings are stored first character in the low byte. Reversing the
  // byte order gives a vector whose unsigned order is strcmp order.
  function automatic logic [WORD_BITS-1:0] order_key(input logic [WORD_BITS-1:0] w);
    logic [WORD_BITS-1:0] k;
    k = '0;
    for (int i = 0; i < WORD_BYTES; i++) begin
      k[8*(WORD_BYTES-1-i) +: 8] = w[8*i +: 8];
    end
    return k;
  endfunction

endpackage

// File: src/wft_if.sv
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one item of a parameterized payload type between source and sink.
// ----------------------------------------------------------------------------
interface wft_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/word_frequency_table.sv
// ----------------------------------------------------------------------------
// Word frequency table
// Counts lower-cased words of a byte stream in a table kept in sorted order.
// ----------------------------------------------------------------------------
// A letter byte is taken while the block is idle. A separator that ends a word
// searches the table memory one entry at a time, waiting on each memory read,
// until the first entry that is not below the word; a match raises the count
// of that entry. A new word then moves each entry above its place up by one
// and is written in its place. A read item goes through the memory read
// port; its result waits in an output register until taken, and a later read
// item waits for that register. The block takes no item while a word is
// being stored or read. No clearing pass is needed after reset. End the text
// with a separator byte.
module word_frequency_table #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int MAX_WORD_LEN  = 16,
  parameter int COUNT_WIDTH   = 24
) (
  input logic clk,
  input logic rst,
  wft_if.sink   in_ch,
  wft_if.source out_ch
);
  import wft_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int ENT_W = WORD_BITS + LEN_W + COUNT_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_RDOUT  = 3'd4;
  localparam logic [2:0] S_SWAIT  = 3'd5;
  localparam logic [2:0] S_SHWAIT = 3'd6;

  logic [ENT_W-1:0] mem [TABLE_ENTRIES];
  logic [ENT_W-1:0] rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;

  logic [2:0]           state;
  logic [WORD_BITS-1:0] pending;
  logic [LEN_W-1:0]     pending_length;
  logic [CNT_W-1:0]     total;
  logic [CNT_W-1:0]     pos;
  logic [CNT_W-1:0]     search_pos;
  logic                 overflow_seen;
  logic                 truncation_seen;
  logic                 rd_valid;
  logic                 rank_ok;
  logic                 out_valid;
  out_item_t            out_data;

  logic [WORD_BITS-1:0]   ent_word;
  logic [LEN_W-1:0]       ent_len;
  logic [COUNT_WIDTH-1:0] ent_cnt;
  logic                   ent_less;
  logic                   ent_equal;
  logic [7:0]             ch;
  logic                   is_upper;
  logic                   is_letter;
  in_item_t               item;
  logic                   accept;
  logic                   insert_write;
  logic                   rd_go;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign item      = in_ch.data;
  assign ch        = item.text_byte;
  assign is_upper  = (ch >= CHAR_UPPER_A) && (ch <= CHAR_UPPER_Z);
  assign is_letter = is_upper || ((ch >= CHAR_LOWER_A) && (ch <= CHAR_LOWER_Z));
  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign ent_word  = rd_data[ENT_W-1 -: WORD_BITS];
  assign ent_len   = rd_data[COUNT_WIDTH +: LEN_W];
  assign ent_cnt   = rd_data[COUNT_WIDTH-1:0];
  assign ent_less  = order_key(ent_word) < order_key(pending);
  assign ent_equal = ent_word == pending;

  assign insert_write = (state == S_SHIFT) && (pos == search_pos);
  assign rd_go        = !out_valid || out_ch.ready;

  always_comb begin
    rd_addr = pos[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = pos[IDX_W-1:0];
    wr_data = rd_data;
    if (accept && item.kind == KIND_READ) begin
      rd_addr = IDX_W'(item.rank);
    end else if (state == S_SEARCH && rd_valid && (pos < total) && !ent_less && ent_equal) begin
      wr_en = 1'b1;
      wr_data = {ent_word, ent_len, (ent_cnt == COUNT_MAX) ? ent_cnt : ent_cnt + 1'b1};
    end else if (insert_write) begin
      wr_en = 1'b1;
      wr_data = {pending, pending_length, COUNT_WIDTH'(1)};
    end else if (state == S_SHIFT) begin
      rd_addr = pos[IDX_W-1:0] - 1'b1;
    end else if (state == S_SHWAIT) begin
      wr_en = 1'b1;
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      pending         <= '0;
      pending_length  <= '0;
      total           <= '0;
      pos             <= '0;
      overflow_seen   <= 1'b0;
      truncation_seen <= 1'b0;
      rd_valid        <= 1'b0;
      rank_ok         <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (state == S_RDOUT && rd_go) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.kind == KIND_READ) begin
              pos     <= CNT_W'(item.rank);
              rank_ok <= 32'(item.rank) < 32'(total);
              state   <= S_READ;
            end else if (is_letter) begin
              if (32'(pending_length) < MAX_WORD_LEN) begin
                pending[8*pending_length[3:0] +: 8] <= is_upper ? ch + CASE_OFFSET : ch;
                pending_length <= pending_length + 1'b1;
              end else begin
                truncation_seen <= 1'b1;
              end
            end else if (pending_length != '0) begin
              pos      <= '0;
              rd_valid <= 1'b0;
              state    <= S_SWAIT;
            end
          end
        end
        S_SWAIT: begin
          rd_valid <= 1'b1;
          state    <= S_SEARCH;
        end
        S_SEARCH: begin
          if (pos >= total) begin
            if (32'(total) >= TABLE_ENTRIES) begin
              overflow_seen  <= 1'b1;
              pending        <= '0;
              pending_length <= '0;
              state          <= S_IDLE;
            end else begin
              pos   <= total;
              state <= S_SHIFT;
            end
          end else if (rd_valid) begin
            if (ent_less) begin
              pos      <= pos + 1'b1;
              rd_valid <= 1'b0;
              state    <= S_SWAIT;
            end else if (ent_equal) begin
              pending        <= '0;
              pending_length <= '0;
              state          <= S_IDLE;
            end else if (32'(total) >= TABLE_ENTRIES) begin
              overflow_seen  <= 1'b1;
              pending        <= '0;
              pending_length <= '0;
              state          <= S_IDLE;
            end else begin
              pos   <= total;
              state <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          if (pos == search_pos) begin
            state <= S_IDLE;
          end else begin
            state <= S_SHWAIT;
          end
        end
        S_SHWAIT: begin
          pos   <= pos - 1'b1;
          state <= S_SHIFT;
        end
        S_READ: begin
          state <= S_RDOUT;
        end
        S_RDOUT: begin
          if (rd_go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (state == S_SHIFT && pos == search_pos) begin
        total          <= total + 1'b1;
        pending        <= '0;
        pending_length <= '0;
      end
    end
  end

  // Insert point captured when the search decides on a new word.
  always_ff @(posedge clk) begin
    if (state == S_SEARCH && (pos >= total || (rd_valid && !ent_less))) begin
      search_pos <= pos;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RDOUT && rd_go) begin
      if (rank_ok) begin
        out_data.word_first_chars <= ent_word[HALF_BITS-1:0];
        out_data.word_last_chars  <= ent_word[WORD_BITS-1:HALF_BITS];
        out_data.word_length      <= ent_len;
        out_data.word_count       <= OUT_COUNT_W'(ent_cnt);
        out_data.entry_valid      <= 1'b1;
      end else begin
        out_data.word_first_chars <= '0;
        out_data.word_last_chars  <= '0;
        out_data.word_length      <= '0;
        out_data.word_count       <= '0;
        out_data.entry_valid      <= 1'b0;
      end
      out_data.distinct_words <= TOTAL_W'(total);
      out_data.table_overflow <= overflow_seen;
      out_data.word_truncated <= truncation_seen;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  assert property (@(posedge clk) disable iff (rst) 32'(total) <= TABLE_ENTRIES)
    else $error("Entry total exceeds table size.");
  assert property (@(posedge clk) disable iff (rst) in_ch.ready |-> state == S_IDLE)
    else $error("Input taken while busy.");
  assert property (@(posedge clk) disable iff (rst) 32'(pending_length) <= MAX_WORD_LEN)
    else $error("Pending word too long.");

endmodule

// File: bench/word_frequency_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Word frequency table checker
// Watches both channels, keeps its own sorted word table, predicts each read
// item's result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module word_frequency_table_checker
  import wft_pkg::*;
#(
  parameter int TABLE_ENTRIES = 1024,
  parameter int MAX_WORD_LEN  = 16,
  parameter int COUNT_WIDTH   = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  in_item_t in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_item_t out_data,
  output int   fail_count,
  output int   waiting_results
);

  logic [WORD_BITS-1:0]   word_mem [TABLE_ENTRIES];
  logic [LEN_W-1:0]       len_mem [TABLE_ENTRIES];
  logic [COUNT_WIDTH-1:0] count_mem [TABLE_ENTRIES];
  logic [WORD_BITS-1:0]   word_acc;
  int                     word_len;
  int                     word_total;
  logic                   overflow_flag;
  logic                   truncate_flag;
  out_item_t              expected_reads[$];

  assign waiting_results = expected_reads.size();

  function automatic logic [WORD_BITS-1:0] sort_key(logic [WORD_BITS-1:0] w);
    logic [WORD_BITS-1:0] k;
    for (int i = 0; i < WORD_BYTES; i++) k[8*(WORD_BYTES-1-i) +: 8] = w[8*i +: 8];
    return k;
  endfunction

  task automatic store_word();
    int pos;
    pos = 0;
    while (pos < word_total && sort_key(word_mem[pos]) < sort_key(word_acc)) pos++;
    if (pos < word_total && word_mem[pos] == word_acc) begin
      if (count_mem[pos] != '1) count_mem[pos]++;
    end else if (word_total >= TABLE_ENTRIES) begin
      overflow_flag = 1'b1;
    end else begin
      for (int i = word_total; i > pos; i--) begin
        word_mem[i] = word_mem[i-1];
        len_mem[i] = len_mem[i-1];
        count_mem[i] = count_mem[i-1];
      end
      word_mem[pos] = word_acc;
      len_mem[pos] = LEN_W'(word_len);
      count_mem[pos] = 1;
      word_total++;
    end
    word_acc = '0;
    word_len = 0;
  endtask

  task automatic take_item(in_item_t it);
    logic [7:0] c;
    out_item_t r;
    c = it.text_byte;
    if (it.kind == KIND_TEXT) begin
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) c = c + CASE_OFFSET;
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
        if (word_len < MAX_WORD_LEN) begin
          word_acc[8*word_len +: 8] = c;
          word_len++;
        end else begin
          truncate_flag = 1'b1;
        end
      end else if (word_len > 0) begin
        store_word();
      end
    end else begin
      r = '0;
      if (it.rank < word_total) begin
        r.word_first_chars = word_mem[it.rank][63:0];
        r.word_last_chars = word_mem[it.rank][127:64];
        r.word_length = len_mem[it.rank];
        r.word_count = count_mem[it.rank][OUT_COUNT_W-1:0];
        r.entry_valid = 1'b1;
      end
      r.distinct_words = TOTAL_W'(word_total);
      r.table_overflow = overflow_flag;
      r.word_truncated = truncate_flag;
      expected_reads.push_back(r);
    end
  endtask

  task automatic compare_read(out_item_t got);
    out_item_t e;
    if (expected_reads.size() == 0) begin
      $error("unexpected result item");
      fail_count++;
      return;
    end
    e = expected_reads.pop_front();
    if (got.word_first_chars !== e.word_first_chars) begin
      $error("word_first_chars exp %h got %h", e.word_first_chars, got.word_first_chars);
      fail_count++;
    end
    if (got.word_last_chars !== e.word_last_chars) begin
      $error("word_last_chars exp %h got %h", e.word_last_chars, got.word_last_chars);
      fail_count++;
    end
    if (got.word_length !== e.word_length) begin
      $error("word_length exp %0d got %0d", e.word_length, got.word_length);
      fail_count++;
    end
    if (got.word_count !== e.word_count) begin
      $error("word_count exp %0d got %0d", e.word_count, got.word_count);
      fail_count++;
    end
    if (got.entry_valid !== e.entry_valid) begin
      $error("entry_valid exp %0d got %0d", e.entry_valid, got.entry_valid);
      fail_count++;
    end
    if (got.distinct_words !== e.distinct_words) begin
      $error("distinct_words exp %0d got %0d", e.distinct_words, got.distinct_words);
      fail_count++;
    end
    if (got.table_overflow !== e.table_overflow) begin
      $error("table_overflow exp %0d got %0d", e.table_overflow, got.table_overflow);
      fail_count++;
    end
    if (got.word_truncated !== e.word_truncated) begin
      $error("word_truncated exp %0d got %0d", e.word_truncated, got.word_truncated);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fail_count = 0;
      word_acc = '0;
      word_len = 0;
      word_total = 0;
      overflow_flag = 1'b0;
      truncate_flag = 1'b0;
      expected_reads.delete();
    end else begin
      if (out_valid && out_ready) compare_read(out_data);
      if (in_valid && in_ready) take_item(in_data);
    end
  end

endmodule

// File: bench/word_frequency_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Word frequency table testbench
// Feeds directed and random text with read items and stalls both sides; the
// checker judges every result.
// ----------------------------------------------------------------------------
module word_frequency_table_tb;
  import wft_pkg::*;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDLE_LIMIT    = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   waiting_results;
  int   idle_cycles = 0;
  int   words_sent = 0;
  logic stall_on = 1'b0;

  wft_if #(in_item_t)  in_ch  (clk);
  wft_if #(out_item_t) out_ch (clk);

  word_frequency_table u_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  word_frequency_table_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_data        (in_ch.data),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_data       (out_ch.data),
    .fail_count     (fail_count),
    .waiting_results(waiting_results)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if ($urandom_range(0, 99) < 3) stall_on <= ~stall_on;
    out_ch.ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (!rst) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("word_frequency_table: mismatch");
        $finish;
      end
    end
  end

  task automatic send(logic k, logic [7:0] b, logic [RANK_W-1:0] r);
    in_item_t it;
    it.kind = k;
    it.text_byte = b;
    it.rank = r;
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if ($urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_word(string w, logic [7:0] sep);
    foreach (w[i]) send(KIND_TEXT, w[i], RANK_W'($urandom));
    send(KIND_TEXT, sep, RANK_W'($urandom));
  endtask

  task automatic send_read(int r);
    send(KIND_READ, 8'($urandom), RANK_W'(r));
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = CHAR_LOWER_A + 8'($urandom_range(0, 3));
    if ($urandom_range(0, 1)) c = c - CASE_OFFSET;
    return c;
  endfunction

  function automatic logic [7:0] rand_sep();
    logic [7:0] c;
    do c = 8'($urandom); while ((c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
                                (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z));
    return c;
  endfunction

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (waiting_results != 0) @(posedge clk);
  endtask

  initial begin
    int n;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_read(0);
    send_read(1023);
    send(KIND_TEXT, 8'h20, 10'h0);
    send_word("Zebra", 8'hFF);
    send_word("apple", 8'h00);
    send_word("AzAz", 8'h40);
    send_word("abcdefghijklmnopqrstuvwxyz", 8'h5B);
    send_word("apple", 8'h7B);
    send_word("a", 8'h60);
    for (int i = 0; i < 5; i++) send_read(i);
    send_read(1023);
    drain();
    while (words_sent < 1200) begin
      if ($urandom_range(0, 5) == 0) begin
        send_read($urandom_range(0, 1) ? $urandom_range(0, 12) : $urandom_range(0, 1023));
        words_sent++;
      end else if ($urandom_range(0, 9) == 0) begin
        send(KIND_TEXT, 8'($urandom), RANK_W'($urandom));
        words_sent++;
      end else begin
        n = $urandom_range(1, 4);
        if ($urandom_range(0, 30) == 0) n = $urandom_range(15, 20);
        for (int i = 0; i < n; i++) send(KIND_TEXT, rand_letter(), RANK_W'($urandom));
        send(KIND_TEXT, rand_sep(), RANK_W'($urandom));
        words_sent += n + 1;
      end
      if (words_sent % 300 < 3) drain();
    end
    for (int i = 0; i < 12; i++) send_read($urandom_range(0, 1023));
    send_read(1023);
    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && waiting_results == 0) begin
      $display("word_frequency_table: match");
    end else begin
      $display("word_frequency_table: mismatch");
    end
    $finish;
  end

endmodule
